[rtl/u8u16_pkg.sv]
// Types, constants and decode functions for the UTF-8 to UTF-16 transcoder.
`timescale 1ns / 1ps

package u8u16_pkg;

    localparam logic [7:0]  LEAD2_MASK = 8'hE0;
    localparam logic [7:0]  LEAD2_CODE = 8'hC0;
    localparam logic [7:0]  LEAD3_MASK = 8'hF0;
    localparam logic [7:0]  LEAD3_CODE = 8'hE0;
    localparam logic [7:0]  LEAD4_MASK = 8'hF8;
    localparam logic [7:0]  LEAD4_CODE = 8'hF0;
    localparam logic [7:0]  PAY2_MASK  = 8'h1F;
    localparam logic [7:0]  PAY3_MASK  = 8'h0F;
    localparam logic [7:0]  PAY4_MASK  = 8'h07;
    localparam logic [7:0]  CONT_MASK  = 8'h3F;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam logic [15:0] HI_SURR    = 16'hD800;
    localparam logic [15:0] LO_SURR    = 16'hDC00;
    localparam logic [20:0] SURR_MASK  = 21'h003FF;

    localparam int          MAX_UNITS  = 4;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] unit_t;
    typedef logic [20:0] point_t;
    typedef logic [2:0]  len_t;

    // Sequence length announced by a lead byte; 1 for anything that is no lead.
    function automatic len_t seq_len(input byte_t b);
        len_t len;
        if ((b & LEAD2_MASK) == LEAD2_CODE)
            len = 3'd2;
        else if ((b & LEAD3_MASK) == LEAD3_CODE)
            len = 3'd3;
        else if ((b & LEAD4_MASK) == LEAD4_CODE)
            len = 3'd4;
        else
            len = 3'd1;
        return len;
    endfunction

    // Assemble a code point from a lead and up to three following bytes.
    function automatic point_t decode_point(input byte_t b0, input byte_t b1,
                                            input byte_t b2, input byte_t b3,
                                            input len_t len);
        point_t cp;
        byte_t  p0;
        byte_t  p1;
        byte_t  p2;
        byte_t  p3;
        p0 = 8'h00;
        p1 = b1 & CONT_MASK;
        p2 = b2 & CONT_MASK;
        p3 = b3 & CONT_MASK;
        case (len)
            3'd2:
            begin
                p0 = b0 & PAY2_MASK;
                cp = {10'h000, p0[4:0], p1[5:0]};
            end
            3'd3:
            begin
                p0 = b0 & PAY3_MASK;
                cp = {5'h00, p0[3:0], p1[5:0], p2[5:0]};
            end
            default:
            begin
                p0 = b0 & PAY4_MASK;
                cp = {p0[2:0], p1[5:0], p2[5:0], p3[5:0]};
            end
        endcase
        return cp;
    endfunction

endpackage

[rtl/utf8_to_utf16_transcoder.sv]
// UTF-8 to UTF-16 transcoder: input register, single-pass decode, result buffer.
//
// Input channel (byte_valid / byte_stall) carries one UTF-8 byte per word with
// byte_present and string_end flags; output channel (unit_valid / unit_stall)
// carries one UTF-16 code unit per word, run_last marking the final unit that
// an input word caused. Each string is closed by a zero terminator unit.
// A word is registered on acceptance and decoded into up to four units, which
// load a small result buffer in one go as soon as that buffer is free. The first
// unit is offered from that buffer, so it passes the input register and then the
// result buffer. The buffer drains one unit per cycle while unit_stall is low,
// so the block then takes one input word per cycle as long as each word
// yields at most one unit; a word that yields more units holds the input
// until its last unit is taken. The next decode loads the buffer in the same
// cycle as its last unit is taken, so there are no bubbles between words.
// Reset clears the input register, the partial-sequence count and the result
// buffer; no clearing pass is needed. While unit_stall is high the shown unit
// holds, a full buffer keeps its units and byte_stall rises once the input register is full.
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        byte_valid,
    output logic        byte_stall,
    input  logic [7:0]  in_byte,
    input  logic        byte_present,
    input  logic        string_end,
    output logic        unit_valid,
    input  logic        unit_stall,
    output logic [15:0] code_unit,
    output logic        run_last
);

    // input register
    logic        item_valid_reg;
    logic        item_valid_next;
    byte_t       item_byte_reg;
    logic        item_present_reg;
    logic        item_end_reg;

    // open sequence
    byte_t       held_reg [3];
    byte_t       held_next [3];
    logic [1:0]  held_count_reg;
    logic [1:0]  held_count_next;

    // result buffer
    unit_t       res_units_reg [MAX_UNITS];
    unit_t       res_units_next [MAX_UNITS];
    logic [2:0]  res_left_reg;
    logic [2:0]  res_left_next;
    logic [1:0]  res_idx_reg;
    logic [1:0]  res_idx_next;

    logic        out_take;
    logic        res_free;
    logic        fire;
    logic        accept;
    logic [2:0]  dec_count;

    assign out_take   = unit_valid && !unit_stall;
    assign res_free   = (res_left_reg == 3'd0) || ((res_left_reg == 3'd1) && out_take);
    assign fire       = item_valid_reg && res_free;
    assign byte_stall = item_valid_reg && !fire;
    assign accept     = byte_valid && !byte_stall;

    assign unit_valid = (res_left_reg != 3'd0);
    assign code_unit  = res_units_reg[res_idx_reg];
    assign run_last   = (res_left_reg == 3'd1);

    // Decode the held bytes plus the new byte in one pass of at most four steps.
    always_comb
    begin
        byte_t      win [8];
        logic [2:0] n;
        logic [2:0] pos;
        logic [2:0] cnt;
        logic       stop;
        byte_t      lead;
        len_t       need;
        point_t     cp;
        point_t     v;
        unit_t      hi;
        unit_t      lo;

        for (int k = 0; k < 8; k++)
            win[k] = 8'h00;
        for (int k = 0; k < 3; k++)
            if (2'(k) < held_count_reg)
                win[k] = held_reg[k];
        win[{1'b0, held_count_reg}] = item_byte_reg;
        n = {1'b0, held_count_reg} + {2'b00, item_present_reg};

        for (int k = 0; k < MAX_UNITS; k++)
            res_units_next[k] = res_units_reg[k];

        pos  = 3'd0;
        cnt  = 3'd0;
        stop = 1'b0;
        for (int s = 0; s < 4; s++)
        begin
            lead = win[pos];
            need = seq_len(lead);
            cp   = decode_point(win[pos], win[pos + 3'd1], win[pos + 3'd2],
                                win[pos + 3'd3], need);
            v    = cp - SUPP_BASE;
            hi   = 16'(v >> 10) + HI_SURR;
            lo   = 16'(v & SURR_MASK) + LO_SURR;
            if (!stop && (pos < n))
            begin
                if (need == 3'd1)
                begin
                    if (cnt < 3'd4)
                    begin
                        res_units_next[cnt[1:0]] = {8'h00, lead};
                        cnt = cnt + 3'd1;
                    end
                    pos = pos + 3'd1;
                end
                else if ((pos + need) <= n)
                begin
                    if (cp <= 21'h0FFFF)
                    begin
                        if (cnt < 3'd4)
                        begin
                            res_units_next[cnt[1:0]] = cp[15:0];
                            cnt = cnt + 3'd1;
                        end
                    end
                    else
                    begin
                        if (cnt < 3'd4)
                        begin
                            res_units_next[cnt[1:0]] = hi;
                            cnt = cnt + 3'd1;
                        end
                        if (cnt < 3'd4)
                        begin
                            res_units_next[cnt[1:0]] = lo;
                            cnt = cnt + 3'd1;
                        end
                    end
                    pos = pos + need;
                end
                else if (item_end_reg)
                begin
                    // cut short by the string end: pass the lead through
                    if (cnt < 3'd4)
                    begin
                        res_units_next[cnt[1:0]] = {8'h00, lead};
                        cnt = cnt + 3'd1;
                    end
                    pos = pos + 3'd1;
                end
                else
                begin
                    stop = 1'b1;
                end
            end
        end

        for (int k = 0; k < 3; k++)
            held_next[k] = win[pos + 3'(k)];
        held_count_next = item_end_reg ? 2'd0 : 2'(n - pos);

        if (item_end_reg && (cnt < 3'd4))
        begin
            res_units_next[cnt[1:0]] = 16'h0000;
            cnt = cnt + 3'd1;
        end
        dec_count = cnt;
    end

    always_comb
    begin
        item_valid_next = item_valid_reg;
        if (accept)
            item_valid_next = 1'b1;
        else if (fire)
            item_valid_next = 1'b0;

        res_left_next = res_left_reg;
        res_idx_next  = res_idx_reg;
        if (fire)
        begin
            res_left_next = dec_count;
            res_idx_next  = 2'd0;
        end
        else if (out_take)
        begin
            res_left_next = res_left_reg - 3'd1;
            res_idx_next  = res_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            held_count_reg <= 2'd0;
            res_left_reg   <= 3'd0;
            res_idx_reg    <= 2'd0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
            res_left_reg   <= res_left_next;
            res_idx_reg    <= res_idx_next;
            if (fire)
                held_count_reg <= held_count_next;
        end
    end

    // payload: no reset
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_byte_reg    <= in_byte;
            item_present_reg <= byte_present;
            item_end_reg     <= string_end;
        end
        if (fire)
        begin
            for (int k = 0; k < 3; k++)
                held_reg[k] <= held_next[k];
            for (int k = 0; k < MAX_UNITS; k++)
                res_units_reg[k] <= res_units_next[k];
        end
    end

endmodule
